@@ rtl/core/etpj_pkg.sv @@
// Shared types and constants of the escape-time Julia unit.
// Used by the channel interfaces, the multiplier unit and the top level.
package etpj_pkg;

  localparam int unsigned WordW   = 32;  // Q4.28 word
  localparam int unsigned FracW   = 28;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef logic signed [WordW-1:0]   word_t;
  typedef logic signed [2*WordW-1:0] prod_t;
  typedef logic [CountW-1:0]         count_t;
  typedef logic [CfgIdxW-1:0]        cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CfgCReal   = 2'd0;
  localparam cfg_idx_t CfgCImag   = 2'd1;
  localparam cfg_idx_t CfgMaxIter = 2'd2;

  // Result of the shared multiplier: the exact product, the product scaled
  // back to a word and saturated, and a flag that saturation took place.
  typedef struct packed {
    prod_t full;
    word_t scaled;
    logic  sat;
  } mul_res_t;

endpackage

@@ rtl/core/etpj_if.sv @@
// Valid/ready channel interfaces of the escape-time Julia unit.
// Depends on etpj_pkg for the field types.
interface etpj_in_if;
  logic                valid;
  logic                ready;
  etpj_pkg::word_t     start_real;
  etpj_pkg::word_t     start_imag;

  modport source (output valid, output start_real, output start_imag, input ready);
  modport sink (input valid, input start_real, input start_imag, output ready);
endinterface

interface etpj_out_if;
  logic                valid;
  logic                ready;
  etpj_pkg::count_t    step_count;
  logic                escaped;

  modport source (output valid, output step_count, output escaped, input ready);
  modport sink (input valid, input step_count, input escaped, output ready);
endinterface

@@ rtl/core/etpj_mul_unit.sv @@
// Shared signed multiplier with a registered product, followed by the
// fixed-point rescale (floor) and saturation to one word. Uses etpj_pkg.
module etpj_mul_unit (
  input  logic               clk_i,
  input  etpj_pkg::word_t    op_a_i,
  input  etpj_pkg::word_t    op_b_i,
  output etpj_pkg::mul_res_t res_o
);

  localparam int unsigned W = etpj_pkg::WordW;
  localparam int unsigned F = etpj_pkg::FracW;

  etpj_pkg::prod_t prod_q;
  logic [2*W-1-(W-1+F):0] top_bits;
  logic ovf;

  always_ff @(posedge clk_i) begin
    prod_q <= etpj_pkg::prod_t'(op_a_i) * etpj_pkg::prod_t'(op_b_i);
  end

  // The rescaled value fits a word only if all bits above it match its sign.
  assign top_bits = prod_q[2*W-1:W-1+F];
  assign ovf      = !((&top_bits) || (~|top_bits));

  always_comb begin
    res_o.full = prod_q;
    res_o.sat  = ovf;
    if (ovf) begin
      res_o.scaled = prod_q[2*W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      res_o.scaled = prod_q[W-1+F:F];
    end
  end

endmodule

@@ rtl/core/escape_time_polynomial_julia_unit.sv @@
// Escape-time iteration of z <- c*z*(1+z/2)^2 in Q4.28 on one shared multiplier.
// Each map step runs through the sub-steps StepMagRe to StepC4. At StepTest the point
// ends if the limit is reached or |z|^2 is not below 100; a map step that saturates
// ends the point at its last sub-step. One point is in work at a time; a new word is
// taken in the cycle after the previous one has moved to the output register.
// Reset (rst_ni low, asynchronous) clears control and loads c = 2.0 + 0i, limit 50.
module escape_time_polynomial_julia_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  etpj_pkg::cfg_idx_t    cfg_index_i,
  input  etpj_pkg::word_t       cfg_wdata_i,
  etpj_in_if.sink               in_i,
  etpj_out_if.source            out_o
);

  localparam int unsigned W  = etpj_pkg::WordW;
  localparam int unsigned F  = etpj_pkg::FracW;
  localparam int unsigned CW = etpj_pkg::CountW;

  localparam etpj_pkg::word_t  One       = etpj_pkg::word_t'(64'd1 << F);
  localparam etpj_pkg::word_t  CRealRst  = etpj_pkg::word_t'(536870912);
  localparam etpj_pkg::word_t  CImagRst  = '0;
  localparam etpj_pkg::count_t MaxIterRst = etpj_pkg::count_t'(50);
  localparam logic [2*W:0]     EscapeThr = (2*W+1)'(100) << (2*F);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  // Sub-steps of one map step.
  localparam logic [3:0] StepMagRe = 4'd0;
  localparam logic [3:0] StepMagIm = 4'd1;
  localparam logic [3:0] StepTest  = 4'd2;
  localparam logic [3:0] StepTre2  = 4'd3;
  localparam logic [3:0] StepTim2  = 4'd4;
  localparam logic [3:0] StepShape = 4'd5;
  localparam logic [3:0] StepP0    = 4'd6;
  localparam logic [3:0] StepP1    = 4'd7;
  localparam logic [3:0] StepP2    = 4'd8;
  localparam logic [3:0] StepP3    = 4'd9;
  localparam logic [3:0] StepP4    = 4'd10;
  localparam logic [3:0] StepC0    = 4'd11;
  localparam logic [3:0] StepC1    = 4'd12;
  localparam logic [3:0] StepC2    = 4'd13;
  localparam logic [3:0] StepC3    = 4'd14;
  localparam logic [3:0] StepC4    = 4'd15;

  // Saturating add or subtract; bit W of the result flags saturation.
  function automatic logic [W:0] sat_sum(input etpj_pkg::word_t a,
                                         input etpj_pkg::word_t b,
                                         input logic sub);
    logic signed [W:0] s;
    logic ovf;
    logic [W-1:0] v;
    s   = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
    ovf = s[W] ^ s[W-1];
    if (ovf) begin
      v = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      v = s[W-1:0];
    end
    return {ovf, v};
  endfunction

  logic [1:0] state_q;
  logic [3:0] step_q;
  etpj_pkg::count_t iter_q, max_iter_q, out_count_q;
  etpj_pkg::word_t  c_real_q, c_imag_q;
  etpj_pkg::word_t  re_q, im_q, tre_q, tim_q, t2_q, t3_q, a_q, b_q;
  logic [2*W-1:0]   sq_q;
  logic             sat_q, out_valid_q, out_esc_q;

  etpj_pkg::word_t    op_a, op_b;
  etpj_pkg::mul_res_t mres;
  logic [W:0]         acc_add, acc_sub, dbl, dif, hlf;
  logic [2*W:0]       mag_sum;
  logic               is_inside, sat_now;

  etpj_mul_unit u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .res_o  (mres)
  );

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step_q)
      StepMagRe: begin op_a = re_q;  op_b = re_q;     end
      StepMagIm: begin op_a = im_q;  op_b = im_q;     end
      StepTest:  begin op_a = tre_q; op_b = tre_q;    end
      StepTre2:  begin op_a = tim_q; op_b = tim_q;    end
      StepTim2:  begin op_a = tre_q; op_b = tim_q;    end
      StepP0:    begin op_a = tre_q; op_b = re_q;     end
      StepP1:    begin op_a = tim_q; op_b = im_q;     end
      StepP2:    begin op_a = tre_q; op_b = im_q;     end
      StepP3:    begin op_a = tim_q; op_b = re_q;     end
      StepC0:    begin op_a = a_q;   op_b = c_real_q; end
      StepC1:    begin op_a = b_q;   op_b = c_imag_q; end
      StepC2:    begin op_a = a_q;   op_b = c_imag_q; end
      StepC3:    begin op_a = b_q;   op_b = c_real_q; end
      default:   begin op_a = '0;    op_b = '0;       end
    endcase
  end

  assign acc_add = sat_sum(t2_q, mres.scaled, 1'b0);
  assign acc_sub = sat_sum(t2_q, mres.scaled, 1'b1);
  assign dbl     = sat_sum(mres.scaled, mres.scaled, 1'b0);
  assign dif     = sat_sum(t2_q, t3_q, 1'b1);
  assign hlf     = sat_sum(re_q >>> 1, One, 1'b0);

  // Squares are never negative, so the full products add as unsigned values.
  assign mag_sum   = {1'b0, sq_q} + {1'b0, mres.full};
  assign is_inside = mag_sum < EscapeThr;
  assign sat_now   = sat_q | mres.sat | acc_add[W];

  assign in_i.ready     = (state_q == StIdle);
  assign out_o.valid    = out_valid_q;
  assign out_o.step_count = out_count_q;
  assign out_o.escaped  = out_esc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_real_q   <= CRealRst;
      c_imag_q   <= CImagRst;
      max_iter_q <= MaxIterRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        etpj_pkg::CfgCReal:   c_real_q   <= cfg_wdata_i;
        etpj_pkg::CfgCImag:   c_imag_q   <= cfg_wdata_i;
        etpj_pkg::CfgMaxIter: max_iter_q <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= StepMagRe;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_i.valid) begin
            state_q <= StRun;
            step_q  <= StepMagRe;
            iter_q  <= '0;
          end
        end
        StRun: begin
          step_q <= step_q + 4'd1;
          if (step_q == StepTest && (iter_q >= max_iter_q || !is_inside)) begin
            state_q <= StDone;
          end
          if (step_q == StepC4) begin
            iter_q <= iter_q + etpj_pkg::count_t'(1);
            if (sat_now) begin
              state_q <= StDone;
            end
          end
        end
        StDone: begin
          if (!out_valid_q || out_o.ready) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (state_q == StDone && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_i.valid) begin
      re_q <= in_i.start_real;
      im_q <= in_i.start_imag;
    end
    if (state_q == StDone && (!out_valid_q || out_o.ready)) begin
      out_count_q <= iter_q;
      out_esc_q   <= iter_q < max_iter_q;
    end
    if (state_q == StRun) begin
      unique case (step_q)
        StepMagRe: ;
        StepMagIm: begin
          sq_q  <= mres.full;
          tre_q <= hlf[W-1:0];
          tim_q <= im_q >>> 1;
          sat_q <= hlf[W];
        end
        StepTest: ;
        StepTre2: begin
          t2_q  <= mres.scaled;
          sat_q <= sat_q | mres.sat;
        end
        StepTim2: begin
          t3_q  <= mres.scaled;
          sat_q <= sat_q | mres.sat;
        end
        StepShape: begin
          tre_q <= dif[W-1:0];
          tim_q <= dbl[W-1:0];
          sat_q <= sat_q | mres.sat | dif[W] | dbl[W];
        end
        StepP0: ;
        StepP1, StepP3, StepC1, StepC3: begin
          t2_q  <= mres.scaled;
          sat_q <= sat_q | mres.sat;
        end
        StepP2: begin
          a_q   <= acc_sub[W-1:0];
          sat_q <= sat_q | mres.sat | acc_sub[W];
        end
        StepP4: begin
          b_q   <= acc_add[W-1:0];
          sat_q <= sat_q | mres.sat | acc_add[W];
        end
        StepC0: ;
        StepC2: begin
          re_q  <= acc_sub[W-1:0];
          sat_q <= sat_q | mres.sat | acc_sub[W];
        end
        StepC4: begin
          im_q  <= acc_add[W-1:0];
          sat_q <= sat_now;
        end
        default: ;
      endcase
    end
  end

endmodule
